FILE: hw/rtl/ctim_pkg.sv
// ctim_pkg: shared types and constants for the countdown timer with alarm
// payload structs for both channels, mode codes, register indexes, stage bundles
// no dependencies
`default_nettype none

package ctim_pkg;

  localparam int unsigned DUR_W      = 26;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [9:0]       DEBOUNCE_RESET = 10'd50;
  localparam logic [15:0]      BLINK_RESET    = 16'd500;
  localparam logic [9:0]       MS_PER_SEC     = 10'd1000;
  localparam logic [DUR_W-1:0] ROUND_UP_MS    = 26'd999;

  // ceil(2^32 / 125), exact for 23-bit dividends
  localparam logic [25:0]  DIV125_RECIP = 26'd34359739;
  localparam int unsigned  DIV125_SHIFT = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK    = 1'b1;

  typedef enum logic [1:0] {
    MODE_REST  = 2'd0,
    MODE_COUNT = 2'd1,
    MODE_ALARM = 2'd2
  } mode_e;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        start_level;
    logic        stop_level;
    logic        command_valid;
    logic [15:0] new_seconds;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] seconds_remaining;
    logic        alarm_led;
  } out_item_t;

  // poll after input registration, with the command already scaled to ms
  typedef struct packed {
    logic [31:0]      now_ms;
    logic             start_level;
    logic             stop_level;
    logic             load;
    logic [15:0]      cmd_secs;
    logic [DUR_W-1:0] cmd_ms;
  } poll_t;

  // timer state seen by the output stage; rem_div means rem_val still needs /1000
  typedef struct packed {
    mode_e            mode;
    logic             alarm_led;
    logic [DUR_W-1:0] rem_val;
    logic             rem_div;
  } core_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ctim_in_stage.sv
// ctim_in_stage: input register of the timer pipeline
// scales a nonzero duration command to milliseconds; uses ctim_pkg
`default_nettype none

module ctim_in_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire ctim_pkg::in_item_t in_data_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output ctim_pkg::poll_t       poll_o
);

  logic            valid_q;
  logic            valid_d;
  ctim_pkg::poll_t poll_q;
  ctim_pkg::poll_t poll_d;
  logic            ready;
  logic            take;

  assign ready      = !valid_q || ready_i;
  assign in_stall_o = !ready;
  assign take       = in_valid_i && ready;

  always_comb begin
    valid_d = valid_q;
    if (ready) begin
      valid_d = in_valid_i;
    end
    poll_d.now_ms      = in_data_i.now_ms;
    poll_d.start_level = in_data_i.start_level;
    poll_d.stop_level  = in_data_i.stop_level;
    poll_d.load        = in_data_i.command_valid && (in_data_i.new_seconds != 16'd0);
    poll_d.cmd_secs    = in_data_i.new_seconds;
    poll_d.cmd_ms      = ctim_pkg::DUR_W'(in_data_i.new_seconds)
                         * ctim_pkg::DUR_W'(ctim_pkg::MS_PER_SEC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      poll_q <= poll_d;
    end
  end

  assign valid_o = valid_q;
  assign poll_o  = poll_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ctim_debounce.sv
// ctim_debounce: one button debouncer with press detect
// accepted level and time stamp of the last accepted change; no dependencies
`default_nettype none

module ctim_debounce (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        level_i,
  input  wire logic [31:0] now_i,
  input  wire logic [9:0]  debounce_i,
  output logic             press_o
);

  logic        state_q;
  logic [31:0] stamp_q;
  logic [31:0] since;
  logic        take;

  // wrapping difference since the last accepted change
  assign since   = now_i - stamp_q;
  assign take    = (level_i != state_q) && (since >= {22'd0, debounce_i});
  assign press_o = take && level_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= 1'b0;
      stamp_q <= 32'd0;
    end else if (en_i && take) begin
      state_q <= level_i;
      stamp_q <= now_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ctim_core.sv
// ctim_core: timer state, configuration registers and mode sequencing
// uses ctim_debounce and ctim_pkg
`default_nettype none

module ctim_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [ctim_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [ctim_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire logic                                valid_i,
  output logic                                     ready_o,
  input  wire ctim_pkg::poll_t                     poll_i,
  output logic                                     valid_o,
  input  wire logic                                ready_i,
  output ctim_pkg::core_state_t                    state_o
);

  localparam int unsigned DW = ctim_pkg::DUR_W;

  logic [9:0]  debounce_q;
  logic [15:0] blink_ms_q;

  logic                  valid_q;
  logic                  adv;
  ctim_pkg::mode_e       mode_q, mode_d;
  logic                  led_q, led_d;
  logic [DW-1:0]         dur_q, dur_d;
  logic [DW-1:0]         rem_val_q, rem_val_d;
  logic                  rem_div_q, rem_div_d;
  logic [31:0]           cstart_q, cstart_d;
  logic [31:0]           blink_q, blink_d;

  logic        start_pr;
  logic        stop_pr;
  logic [31:0] elapsed;
  logic        expired;
  logic [DW-1:0] count_left;
  logic [31:0] blink_since;
  logic        blink_due;

  assign ready_o = !valid_q || ready_i;
  assign adv     = valid_i && ready_o;

  ctim_debounce u_start_db (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .level_i    (poll_i.start_level),
    .now_i      (poll_i.now_ms),
    .debounce_i (debounce_q),
    .press_o    (start_pr)
  );

  ctim_debounce u_stop_db (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .level_i    (poll_i.stop_level),
    .now_i      (poll_i.now_ms),
    .debounce_i (debounce_q),
    .press_o    (stop_pr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= ctim_pkg::DEBOUNCE_RESET;
      blink_ms_q <= ctim_pkg::BLINK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ctim_pkg::REG_DEBOUNCE: debounce_q <= cfg_wdata_i[9:0];
        ctim_pkg::REG_BLINK:    blink_ms_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // a command takes effect before the mode step, in any mode
  assign dur_d       = poll_i.load ? poll_i.cmd_ms : dur_q;
  assign elapsed     = poll_i.now_ms - cstart_q;
  assign expired     = elapsed >= {6'd0, dur_d};
  // only used while elapsed < duration, so the low bits suffice
  assign count_left  = dur_d - elapsed[DW-1:0] + ctim_pkg::ROUND_UP_MS;
  assign blink_since = poll_i.now_ms - blink_q;
  assign blink_due   = blink_since >= {16'd0, blink_ms_q};

  always_comb begin
    mode_d    = mode_q;
    led_d     = led_q;
    cstart_d  = cstart_q;
    blink_d   = blink_q;
    rem_val_d = rem_val_q;
    rem_div_d = rem_div_q;
    if (poll_i.load) begin
      rem_val_d = DW'(poll_i.cmd_secs);
      rem_div_d = 1'b0;
    end
    case (mode_q)
      ctim_pkg::MODE_COUNT: begin
        if (stop_pr) begin
          rem_val_d = '0;
          rem_div_d = 1'b0;
          mode_d    = ctim_pkg::MODE_REST;
        end else if (expired) begin
          rem_val_d = '0;
          rem_div_d = 1'b0;
          mode_d    = ctim_pkg::MODE_ALARM;
          blink_d   = poll_i.now_ms;
        end else begin
          rem_val_d = count_left;
          rem_div_d = 1'b1;
        end
      end
      ctim_pkg::MODE_ALARM: begin
        if (stop_pr) begin
          led_d  = 1'b0;
          mode_d = ctim_pkg::MODE_REST;
        end else if (blink_due) begin
          led_d   = !led_q;
          blink_d = poll_i.now_ms;
        end
      end
      default: begin
        mode_d = ctim_pkg::MODE_REST;
        led_d  = 1'b0;
        if (start_pr && (dur_d != '0)) begin
          mode_d    = ctim_pkg::MODE_COUNT;
          rem_val_d = dur_d;
          rem_div_d = 1'b1;
          cstart_d  = poll_i.now_ms;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      mode_q    <= ctim_pkg::MODE_REST;
      led_q     <= 1'b0;
      dur_q     <= '0;
      rem_val_q <= '0;
      rem_div_q <= 1'b0;
      cstart_q  <= 32'd0;
      blink_q   <= 32'd0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (adv) begin
        mode_q    <= mode_d;
        led_q     <= led_d;
        dur_q     <= dur_d;
        rem_val_q <= rem_val_d;
        rem_div_q <= rem_div_d;
        cstart_q  <= cstart_d;
        blink_q   <= blink_d;
      end
    end
  end

  // the state registers always hold the state left by the beat in this stage
  assign valid_o           = valid_q;
  assign state_o.mode      = mode_q;
  assign state_o.alarm_led = led_q;
  assign state_o.rem_val   = rem_val_q;
  assign state_o.rem_div   = rem_div_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ctim_out_stage.sv
// ctim_out_stage: seconds conversion and result register
// divides by 1000 as a shift by 3 and a reciprocal multiply by 125; uses ctim_pkg
`default_nettype none

module ctim_out_stage (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire ctim_pkg::core_state_t state_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output ctim_pkg::out_item_t        out_data_o
);

  localparam int unsigned QW = ctim_pkg::DUR_W - 3;
  localparam int unsigned PW = QW + 26;

  logic                valid_q;
  ctim_pkg::out_item_t data_q;
  ctim_pkg::out_item_t data_d;
  logic [PW-1:0]       prod;
  logic                take;

  assign ready_o = !valid_q || !out_stall_i;
  assign take    = valid_i && ready_o;

  assign prod = PW'(state_i.rem_val[ctim_pkg::DUR_W-1:3]) * PW'(ctim_pkg::DIV125_RECIP);

  always_comb begin
    data_d.mode      = state_i.mode;
    data_d.alarm_led = state_i.alarm_led;
    if (state_i.rem_div) begin
      data_d.seconds_remaining = prod[ctim_pkg::DIV125_SHIFT +: 16];
    end else begin
      data_d.seconds_remaining = state_i.rem_val[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

FILE: hw/rtl/countdown_timer_with_alarm_top.sv
// countdown_timer_with_alarm_top: debounced countdown timer with blinking alarm
// uses ctim_in_stage, ctim_core, ctim_debounce, ctim_out_stage, ctim_pkg
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o   in_data_i   (ctim_pkg::in_item_t)
//   out      output     out_valid_o / out_stall_i out_data_o  (ctim_pkg::out_item_t)
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// three register stages: input register, timer state, result register
// one poll per cycle unless a stalled output backs the stages up
// the timer state loop (debounce, mode step) closes inside ctim_core
// a stalled output holds its beat; free stages upstream still fill
// reset clears all valids, the timer state and the configuration registers to their defaults
`default_nettype none

module countdown_timer_with_alarm_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire ctim_pkg::in_item_t               in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output ctim_pkg::out_item_t                   out_data_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [ctim_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [ctim_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  logic                  poll_valid;
  logic                  poll_ready;
  ctim_pkg::poll_t       poll;
  logic                  st_valid;
  logic                  st_ready;
  ctim_pkg::core_state_t st;

  ctim_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .valid_o    (poll_valid),
    .ready_i    (poll_ready),
    .poll_o     (poll)
  );

  ctim_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (poll_valid),
    .ready_o     (poll_ready),
    .poll_i      (poll),
    .valid_o     (st_valid),
    .ready_i     (st_ready),
    .state_o     (st)
  );

  ctim_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (st_valid),
    .ready_o     (st_ready),
    .state_i     (st),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/ctim_checker.sv
// ctim_checker: port-level checks for the countdown timer
// bound to countdown_timer_with_alarm_top; uses ctim_pkg
`default_nettype none

module ctim_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire ctim_pkg::out_item_t out_data_o
);

  // a stalled result beat stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped under stall");

  // and keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result payload changed under stall");

  // the led is only lit in alarm
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.mode == ctim_pkg::MODE_REST
                    || out_data_o.mode == ctim_pkg::MODE_COUNT)
    |-> !out_data_o.alarm_led)
    else $error("alarm led lit outside alarm");

  // a running countdown always shows at least one second
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.mode == ctim_pkg::MODE_COUNT
    |-> out_data_o.seconds_remaining != 16'd0)
    else $error("countdown shows zero seconds");

endmodule

bind countdown_timer_with_alarm_top ctim_checker u_ctim_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
